/* rtl/alm_pkg.sv */
// Shared types and constants of the analog logic mixer.
package alm_pkg;

  localparam int PIPE_DEPTH = 10;

  typedef enum logic [2:0] {
    REG_LOGIC_MODE        = 3'd0,
    REG_TYPE_A            = 3'd1,
    REG_TYPE_B            = 3'd2,
    REG_THRESHOLD_BASE    = 3'd3,
    REG_THRESHOLD_CV_GAIN = 3'd4,
    REG_EARTH_GAIN        = 3'd5,
    REG_WIND_GAIN         = 3'd6,
    REG_FIRE_GAIN         = 3'd7
  } reg_idx_t;

  localparam logic [1:0] MODE_MINMAX = 2'd0;
  localparam logic [1:0] MODE_MULAVG = 2'd1;
  localparam logic [1:0] TYPE_DIV5   = 2'd0;

  localparam logic [17:0]        RECIP5     = 18'd209715;  // floor(2^20 / 5)
  localparam int                 RECIP_SHIFT = 20;
  localparam logic [16:0]        DIVISOR5   = 17'd5;
  localparam logic signed [13:0] ONE_Q12    = 14'sd4096;
  localparam logic signed [16:0] VOLT_POS   = 17'sd40960;
  localparam logic signed [16:0] VOLT_NEG   = -17'sd40960;
  localparam logic signed [17:0] MIX_POS    = 18'sd131071;
  localparam logic signed [17:0] MIX_NEG    = -18'sd131072;
  localparam logic [13:0]        FIRE_RESET = 14'd4096;

  typedef struct packed {
    logic [1:0]         logic_mode;
    logic [1:0]         type_a;
    logic [1:0]         type_b;
    logic signed [13:0] threshold_base;
    logic [12:0]        threshold_cv_gain;
    logic [12:0]        earth_gain;
    logic [12:0]        wind_gain;
    logic [13:0]        fire_gain;
  } cfg_t;

  typedef struct packed {
    logic               da;
    logic               dor;
    logic signed [16:0] va;
    logic signed [16:0] vo;
  } logic_res_t;

endpackage

/* rtl/alm_divide.sv */
// Input division by 5 or 10 and threshold computation, two stages.
module alm_divide (
  input  logic               clk,
  input  logic [1:0]         en,
  input  alm_pkg::cfg_t      cfg,
  input  logic signed [16:0] a_voltage,
  input  logic signed [16:0] b_voltage,
  input  logic signed [16:0] thresh_cv_voltage,
  output logic signed [14:0] a_scaled,
  output logic signed [14:0] b_scaled,
  output logic signed [18:0] threshold
);
  import alm_pkg::*;

  logic [16:0]        mag_a, mag_b;
  logic [34:0]        prod_a, prod_b;
  logic signed [30:0] cv_prod;

  logic [16:0]        mag_a_r, mag_b_r;
  logic [13:0]        q0_a_r, q0_b_r;
  logic               sign_a_r, sign_b_r;
  logic signed [30:0] cv_prod_r;

  logic [13:0]        q_a, q_b;
  logic signed [30:0] cv_bias;
  logic signed [18:0] cv_term;

  logic signed [14:0] a_scaled_r, b_scaled_r;
  logic signed [18:0] threshold_r;

  // q0 is the true quotient or one less; one compare fixes it
  function automatic logic [13:0] div_fix(input logic [16:0] mag, input logic [13:0] q0,
                                          input logic by_ten);
    logic [16:0] rem;
    logic [13:0] q5;
    rem = mag - ({1'b0, q0, 2'b00} + {3'd0, q0});
    q5  = (rem >= DIVISOR5) ? q0 + 14'd1 : q0;
    div_fix = by_ten ? {1'b0, q5[13:1]} : q5;
  endfunction

  assign mag_a   = a_voltage[16] ? $unsigned(-a_voltage) : $unsigned(a_voltage);
  assign mag_b   = b_voltage[16] ? $unsigned(-b_voltage) : $unsigned(b_voltage);
  assign prod_a  = mag_a * RECIP5;
  assign prod_b  = mag_b * RECIP5;
  assign cv_prod = thresh_cv_voltage * $signed({1'b0, cfg.threshold_cv_gain});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag_a_r   <= mag_a;
      mag_b_r   <= mag_b;
      q0_a_r    <= prod_a[RECIP_SHIFT+13:RECIP_SHIFT];
      q0_b_r    <= prod_b[RECIP_SHIFT+13:RECIP_SHIFT];
      sign_a_r  <= a_voltage[16];
      sign_b_r  <= b_voltage[16];
      cv_prod_r <= cv_prod;
    end
  end

  assign q_a     = div_fix(mag_a_r, q0_a_r, cfg.type_a != TYPE_DIV5);
  assign q_b     = div_fix(mag_b_r, q0_b_r, cfg.type_b != TYPE_DIV5);
  assign cv_bias = cv_prod_r + $signed({19'd0, {12{cv_prod_r[30]}}});
  assign cv_term = cv_bias[30:12];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      a_scaled_r  <= sign_a_r ? -$signed({1'b0, q_a}) : $signed({1'b0, q_a});
      b_scaled_r  <= sign_b_r ? -$signed({1'b0, q_b}) : $signed({1'b0, q_b});
      threshold_r <= $signed({{5{cfg.threshold_base[13]}}, cfg.threshold_base}) + cv_term;
    end
  end

  assign a_scaled  = a_scaled_r;
  assign b_scaled  = b_scaled_r;
  assign threshold = threshold_r;

endmodule

/* rtl/alm_logic.sv */
// Logic model, scale by 5 with clamp, and threshold compare, two stages.
module alm_logic (
  input  logic                clk,
  input  logic [1:0]          en,
  input  alm_pkg::cfg_t       cfg,
  input  logic signed [14:0]  a_scaled,
  input  logic signed [14:0]  b_scaled,
  input  logic signed [18:0]  threshold,
  output alm_pkg::logic_res_t res
);
  import alm_pkg::*;

  logic signed [29:0] prod, prod_bias;
  logic signed [15:0] sum, sum_bias;
  logic signed [14:0] a_bias, b_bias;
  logic signed [2:0]  ia, ib, and_int, or_int;
  logic signed [16:0] raw_and, raw_or;

  logic signed [16:0] raw_and_r, raw_or_r;
  logic signed [18:0] threshold_r;

  logic signed [19:0] scaled_and, scaled_or;
  logic signed [16:0] va, vo;
  logic_res_t         res_r;

  function automatic logic signed [16:0] clamp_volt(input logic signed [19:0] s);
    if (s > 20'(VOLT_POS)) begin
      clamp_volt = VOLT_POS;
    end else if (s < 20'(VOLT_NEG)) begin
      clamp_volt = VOLT_NEG;
    end else begin
      clamp_volt = s[16:0];
    end
  endfunction

  assign prod      = a_scaled * b_scaled;
  assign prod_bias = prod + $signed({18'd0, {12{prod[29]}}});
  assign sum       = a_scaled + b_scaled;
  assign sum_bias  = sum + $signed({15'd0, sum[15]});
  assign a_bias    = a_scaled + $signed({3'd0, {12{a_scaled[14]}}});
  assign b_bias    = b_scaled + $signed({3'd0, {12{b_scaled[14]}}});
  assign ia        = a_bias[14:12];
  assign ib        = b_bias[14:12];
  assign and_int   = ia & ib;
  assign or_int    = ia | ib;

  always_comb begin
    unique case (cfg.logic_mode)
      MODE_MINMAX: begin
        raw_and = (a_scaled < b_scaled) ? 17'(a_scaled) : 17'(b_scaled);
        raw_or  = (a_scaled < b_scaled) ? 17'(b_scaled) : 17'(a_scaled);
      end
      MODE_MULAVG: begin
        raw_and = prod_bias[28:12];
        raw_or  = 17'($signed(sum_bias[15:1]));
      end
      default: begin
        raw_and = {{2{and_int[2]}}, and_int, 12'd0};
        raw_or  = {{2{or_int[2]}}, or_int, 12'd0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      raw_and_r   <= raw_and;
      raw_or_r    <= raw_or;
      threshold_r <= threshold;
    end
  end

  assign scaled_and = (raw_and_r <<< 2) + raw_and_r;
  assign scaled_or  = (raw_or_r <<< 2) + raw_or_r;
  assign va         = clamp_volt(scaled_and);
  assign vo         = clamp_volt(scaled_or);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      res_r.va  <= va;
      res_r.vo  <= vo;
      res_r.da  <= $signed({{2{va[16]}}, va}) > threshold_r;
      res_r.dor <= $signed({{2{vo[16]}}, vo}) > threshold_r;
    end
  end

  assign res = res_r;

endmodule

/* rtl/alm_blend.sv */
// Earth, wind and fire blend of the logic results, six stages.
module alm_blend (
  input  logic                clk,
  input  logic [5:0]          en,
  input  alm_pkg::cfg_t       cfg,
  input  alm_pkg::logic_res_t res,
  output alm_pkg::logic_res_t res_out,
  output logic signed [17:0]  mix_voltage
);
  import alm_pkg::*;

  logic signed [13:0] e_s, ne_s, w_s, nw_s;
  logic signed [14:0] f_s;
  logic signed [16:0] dig_and, dig_or;

  logic signed [31:0] sde_r, sae_r;
  logic signed [31:0] sde_bias, sae_bias;
  logic signed [19:0] de_r, ae_r;
  logic signed [33:0] smix_r, smix_bias;
  logic signed [21:0] mi_r;
  logic signed [36:0] fp_r, fp_bias;
  logic signed [24:0] mt;
  logic signed [17:0] mix_r;

  logic_res_t         res_r [6];

  assign e_s     = $signed({1'b0, cfg.earth_gain});
  assign ne_s    = ONE_Q12 - e_s;
  assign w_s     = $signed({1'b0, cfg.wind_gain});
  assign nw_s    = ONE_Q12 - w_s;
  assign f_s     = $signed({1'b0, cfg.fire_gain});
  assign dig_and = res.da ? VOLT_POS : '0;
  assign dig_or  = res.dor ? VOLT_POS : '0;

  assign sde_bias  = sde_r + $signed({20'd0, {12{sde_r[31]}}});
  assign sae_bias  = sae_r + $signed({20'd0, {12{sae_r[31]}}});
  assign smix_bias = smix_r + $signed({22'd0, {12{smix_r[33]}}});
  assign fp_bias   = fp_r + $signed({25'd0, {12{fp_r[36]}}});
  assign mt        = fp_bias[36:12];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sde_r <= e_s * dig_and + ne_s * dig_or;
      sae_r <= e_s * $signed(res.va) + ne_s * $signed(res.vo);
    end
    if (en[1]) begin
      de_r <= sde_bias[31:12];
      ae_r <= sae_bias[31:12];
    end
    if (en[2]) begin
      smix_r <= w_s * de_r + nw_s * ae_r;
    end
    if (en[3]) begin
      mi_r <= smix_bias[33:12];
    end
    if (en[4]) begin
      fp_r <= f_s * mi_r;
    end
    if (en[5]) begin
      if (mt > 25'(MIX_POS)) begin
        mix_r <= MIX_POS;
      end else if (mt < 25'(MIX_NEG)) begin
        mix_r <= MIX_NEG;
      end else begin
        mix_r <= mt[17:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      res_r[0] <= res;
    end
    for (int k = 1; k < 6; k++) begin
      if (en[k]) begin
        res_r[k] <= res_r[k-1];
      end
    end
  end

  assign res_out     = res_r[5];
  assign mix_voltage = mix_r;

endmodule

/* rtl/analog_logic_mixer.sv */
// Top level of the analog logic mixer: config registers, stage control, datapath.
// Throughput: one beat per cycle while out_tready is high; empty stages fill while it is low.
// in_tready drops only when every stage holds a beat and out_tready is low.
// Reset (synchronous, rst_n low) clears all stage valid bits and loads the
// register defaults: all zero, fire_gain 4096.
module analog_logic_mixer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // a_voltage, b_voltage, thresh_cv_voltage, pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // digital_and, digital_or, analog_and, analog_or,
                                  // mix_voltage, pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [13:0] cfg_data
);
  import alm_pkg::*;

  cfg_t                cfg_r, cfg_nxt;
  logic [PIPE_DEPTH:1] v_r, v_nxt;
  logic [PIPE_DEPTH:1] ld;

  logic signed [14:0]  a_scaled, b_scaled;
  logic signed [18:0]  threshold;
  logic_res_t          logic_res, final_res;
  logic signed [17:0]  mix_voltage;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_LOGIC_MODE:        cfg_nxt.logic_mode        = cfg_data[1:0];
        REG_TYPE_A:            cfg_nxt.type_a            = cfg_data[1:0];
        REG_TYPE_B:            cfg_nxt.type_b            = cfg_data[1:0];
        REG_THRESHOLD_BASE:    cfg_nxt.threshold_base    = $signed(cfg_data);
        REG_THRESHOLD_CV_GAIN: cfg_nxt.threshold_cv_gain = cfg_data[12:0];
        REG_EARTH_GAIN:        cfg_nxt.earth_gain        = cfg_data[12:0];
        REG_WIND_GAIN:         cfg_nxt.wind_gain         = cfg_data[12:0];
        REG_FIRE_GAIN:         cfg_nxt.fire_gain         = cfg_data;
      endcase
    end
  end

  // a stage loads when empty or when the stage after it loads
  always_comb begin
    ld[PIPE_DEPTH] = !v_r[PIPE_DEPTH] || out_tready;
    for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  always_comb begin
    v_nxt[1] = ld[1] ? in_tvalid : v_r[1];
    for (int k = 2; k <= PIPE_DEPTH; k++) begin
      v_nxt[k] = ld[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      cfg_r <= '{logic_mode: '0, type_a: '0, type_b: '0, threshold_base: '0,
                 threshold_cv_gain: '0, earth_gain: '0, wind_gain: '0,
                 fire_gain: FIRE_RESET};
    end else begin
      v_r   <= v_nxt;
      cfg_r <= cfg_nxt;
    end
  end

  alm_divide u_divide (
    .clk               (clk),
    .en                (ld[2:1]),
    .cfg               (cfg_r),
    .a_voltage         ($signed(in_tdata[16:0])),
    .b_voltage         ($signed(in_tdata[33:17])),
    .thresh_cv_voltage ($signed(in_tdata[50:34])),
    .a_scaled          (a_scaled),
    .b_scaled          (b_scaled),
    .threshold         (threshold)
  );

  alm_logic u_logic (
    .clk       (clk),
    .en        (ld[4:3]),
    .cfg       (cfg_r),
    .a_scaled  (a_scaled),
    .b_scaled  (b_scaled),
    .threshold (threshold),
    .res       (logic_res)
  );

  alm_blend u_blend (
    .clk         (clk),
    .en          (ld[10:5]),
    .cfg         (cfg_r),
    .res         (logic_res),
    .res_out     (final_res),
    .mix_voltage (mix_voltage)
  );

  assign in_tready  = ld[1];
  assign out_tvalid = v_r[PIPE_DEPTH];
  assign out_tdata  = {2'b00, mix_voltage, final_res.vo, final_res.va,
                       final_res.dor, final_res.da};

endmodule

/* rtl/alm_checker.sv */
// Port-level checks of the analog logic mixer, bound to the top level.
module alm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled while output stage can advance");

  a_and_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[18:2]) <= 17'sd40960) &&
                   ($signed(out_tdata[18:2]) >= -17'sd40960))
    else $error("analog_and outside clamp range");

  a_or_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[35:19]) <= 17'sd40960) &&
                   ($signed(out_tdata[35:19]) >= -17'sd40960))
    else $error("analog_or outside clamp range");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:54] == 2'b00)
    else $error("output pad bits not zero");

endmodule

bind analog_logic_mixer alm_checker u_alm_checker (.*);
